// ===== rtl/core/amdfs_pkg.sv =====
// Shared constants, command codes and control types for the adjacency matrix DFS block.
package amdfs_pkg;

  localparam int NODE_COUNT = 8;
  localparam int NODE_W     = 3;
  localparam int SCAN_W     = 4;
  localparam int DEPTH_W    = 4;
  localparam int TIME_W     = 5;
  localparam int PRED_W     = 4;
  localparam int CMD_W      = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR    = 3'd0,
    CMD_INSERT   = 3'd1,
    CMD_DELETE   = 3'd2,
    CMD_DEL_NODE = 3'd3,
    CMD_TRAVERSE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    COLOR_WHITE = 2'd0,
    COLOR_GRAY  = 2'd1,
    COLOR_BLACK = 2'd2
  } color_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ROOT,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_EDIT,
    DP_INIT,
    DP_ROOT,
    DP_SCAN,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic root_white;
    logic root_last;
    logic pop_last;
    logic emit_last;
  } dp_status_t;

endpackage

// ===== rtl/core/amdfs_ctrl.sv =====
// Controller state machine sequencing edits, the search and the result stream.
module amdfs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2:0]            cmd,
  input  amdfs_pkg::dp_status_t status,
  output amdfs_pkg::dp_cmd_t    dp_cmd,
  output logic                  busy,
  output logic                  strobe
);
  import amdfs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start && (cmd == CMD_TRAVERSE)) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        state_next = S_ROOT;
      end
      S_ROOT: begin
        priority if (status.root_white) begin
          state_next = S_SCAN;
        end else if (status.root_last) begin
          state_next = S_EMIT;
        end
      end
      S_SCAN: begin
        if (status.pop_last) begin
          state_next = status.root_last ? S_EMIT : S_ROOT;
        end
      end
      S_EMIT: begin
        if (status.emit_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd.op = DP_NONE;
    busy      = 1'b1;
    strobe    = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start && (cmd != CMD_TRAVERSE)) begin
          dp_cmd.op = DP_EDIT;
        end
      end
      S_INIT: dp_cmd.op = DP_INIT;
      S_ROOT: dp_cmd.op = DP_ROOT;
      S_SCAN: dp_cmd.op = DP_SCAN;
      S_EMIT: begin
        dp_cmd.op = DP_EMIT;
        strobe    = 1'b1;
      end
      default: dp_cmd.op = DP_NONE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && status.emit_last) |=> !busy)
    else $error("busy still high after last word");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start && cmd == CMD_TRAVERSE) |=> (state == S_INIT))
    else $error("traverse word not taken");

  assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("strobe without preceding traversal");

endmodule

// ===== rtl/core/amdfs_dp.sv =====
// Datapath: adjacency matrix, search stacks, time stamps and result selection.
module amdfs_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  amdfs_pkg::dp_cmd_t    dp_cmd,
  input  logic [2:0]            cmd,
  input  logic [2:0]            node_a,
  input  logic [2:0]            node_b,
  output amdfs_pkg::dp_status_t status,
  output logic [2:0]            node_index,
  output logic [4:0]            discovery_time,
  output logic [4:0]            finish_time,
  output logic signed [3:0]     predecessor,
  output logic                  last_result
);
  import amdfs_pkg::*;

  logic [NODE_COUNT-1:0] adj [NODE_COUNT];
  color_t                color [NODE_COUNT];
  logic [TIME_W-1:0]     disc [NODE_COUNT];
  logic [TIME_W-1:0]     fin [NODE_COUNT];
  logic [PRED_W-1:0]     pred [NODE_COUNT];
  logic [NODE_W-1:0]     node_stack [NODE_COUNT];
  logic [SCAN_W-1:0]     nn_stack [NODE_COUNT];

  logic [TIME_W-1:0]     time_count;
  logic [DEPTH_W-1:0]    depth;
  logic [NODE_W-1:0]     root;
  logic [NODE_W-1:0]     out_idx;

  logic [NODE_W-1:0]     top;
  logic [NODE_W-1:0]     push_idx;
  logic [NODE_W-1:0]     x;
  logic [SCAN_W-1:0]     v;
  logic [NODE_W-1:0]     vi;
  logic                  v_in;
  logic                  hit;
  logic                  room;
  logic [TIME_W-1:0]     time_inc;
  logic                  a_ok;
  logic                  b_ok;

  assign top      = NODE_W'(depth - DEPTH_W'(1));
  assign push_idx = depth[NODE_W-1:0];
  assign x        = node_stack[top];
  assign v        = nn_stack[top];
  assign vi       = v[NODE_W-1:0];
  assign v_in     = v < SCAN_W'(NODE_COUNT);
  assign hit      = v_in && adj[x][vi] && (color[vi] == COLOR_WHITE);
  assign room     = depth < DEPTH_W'(NODE_COUNT);
  assign time_inc = time_count + TIME_W'(1);
  assign a_ok     = {1'b0, node_a} < SCAN_W'(NODE_COUNT);
  assign b_ok     = {1'b0, node_b} < SCAN_W'(NODE_COUNT);

  assign status.root_white = (color[root] == COLOR_WHITE);
  assign status.root_last  = (root == NODE_W'(NODE_COUNT - 1));
  assign status.pop_last   = !v_in && (depth == DEPTH_W'(1));
  assign status.emit_last  = (out_idx == NODE_W'(NODE_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NODE_COUNT; k++) begin
        adj[k] <= '0;
      end
    end else if (dp_cmd.op == DP_EDIT) begin
      unique case (cmd)
        CMD_CLEAR: begin
          for (int k = 0; k < NODE_COUNT; k++) begin
            adj[k] <= '0;
          end
        end
        CMD_INSERT: begin
          if (a_ok && b_ok) begin
            adj[node_a][node_b] <= 1'b1;
            adj[node_b][node_a] <= 1'b1;
          end
        end
        CMD_DELETE: begin
          if (a_ok && b_ok) begin
            adj[node_a][node_b] <= 1'b0;
            adj[node_b][node_a] <= 1'b0;
          end
        end
        CMD_DEL_NODE: begin
          if (a_ok) begin
            for (int k = 0; k < NODE_COUNT; k++) begin
              if (NODE_W'(k) == node_a) begin
                adj[k] <= '0;
              end else begin
                adj[k][node_a] <= 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_count <= '0;
      depth      <= '0;
      root       <= '0;
      out_idx    <= '0;
    end else begin
      unique case (dp_cmd.op)
        DP_INIT: begin
          time_count <= '0;
          depth      <= '0;
          root       <= '0;
          out_idx    <= '0;
        end
        DP_ROOT: begin
          if (color[root] == COLOR_WHITE) begin
            time_count <= time_inc;
            depth      <= DEPTH_W'(1);
          end else begin
            root <= root + NODE_W'(1);
          end
        end
        DP_SCAN: begin
          if (hit) begin
            if (room) begin
              time_count <= time_inc;
              depth      <= depth + DEPTH_W'(1);
            end
          end else if (!v_in) begin
            time_count <= time_inc;
            depth      <= depth - DEPTH_W'(1);
            if (depth == DEPTH_W'(1)) begin
              root <= root + NODE_W'(1);
            end
          end
        end
        DP_EMIT: begin
          out_idx <= out_idx + NODE_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (dp_cmd.op)
      DP_INIT: begin
        for (int k = 0; k < NODE_COUNT; k++) begin
          color[k] <= COLOR_WHITE;
          pred[k]  <= '1;
        end
      end
      DP_ROOT: begin
        if (color[root] == COLOR_WHITE) begin
          color[root]   <= COLOR_GRAY;
          disc[root]    <= time_inc;
          node_stack[0] <= root;
          nn_stack[0]   <= '0;
        end
      end
      DP_SCAN: begin
        if (v_in) begin
          nn_stack[top] <= v + SCAN_W'(1);
        end
        if (hit) begin
          pred[vi] <= PRED_W'(x);
          if (room) begin
            color[vi]            <= COLOR_GRAY;
            disc[vi]             <= time_inc;
            node_stack[push_idx] <= vi;
            nn_stack[push_idx]   <= '0;
          end
        end else if (!v_in) begin
          color[x] <= COLOR_BLACK;
          fin[x]   <= time_inc;
        end
      end
      default: begin
      end
    endcase
  end

  assign node_index     = out_idx;
  assign discovery_time = disc[out_idx];
  assign finish_time    = fin[out_idx];
  assign predecessor    = pred[out_idx];
  assign last_result    = status.emit_last;

  assert property (@(posedge clk) disable iff (rst)
    (dp_cmd.op == DP_SCAN) |-> (depth != '0))
    else $error("scan with empty stack");

  assert property (@(posedge clk) disable iff (rst)
    (dp_cmd.op == DP_ROOT) |-> (depth == '0))
    else $error("root tried with nonempty stack");

  assert property (@(posedge clk) disable iff (rst)
    (dp_cmd.op == DP_SCAN && status.pop_last) |=> (depth == '0))
    else $error("stack not empty after last pop");

  assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(NODE_COUNT))
    else $error("stack overflow");

endmodule

// ===== rtl/core/adjacency_matrix_dfs_timestamps.sv =====
// Top level: undirected graph with depth-first search discovery and finish times.
// Edit words (clear, insert, delete edge, delete node) are taken while idle; busy stays low.
// Traverse: an init step, then each root index is tried in turn; every pushed node scans
// its N = 8 neighbour slots before it is popped. Then one result word per cycle follows,
// with busy high until the last word has been shown.
// Synchronous reset clears the matrix and returns the controller to idle at once.
module adjacency_matrix_dfs_timestamps (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        cmd,
  input  logic [2:0]        node_a,
  input  logic [2:0]        node_b,
  output logic              strobe,
  output logic [2:0]        node_index,
  output logic [4:0]        discovery_time,
  output logic [4:0]        finish_time,
  output logic signed [3:0] predecessor,
  output logic              last_result
);
  import amdfs_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t status;

  amdfs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .status (status),
    .dp_cmd (dp_cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  amdfs_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .dp_cmd         (dp_cmd),
    .cmd            (cmd),
    .node_a         (node_a),
    .node_b         (node_b),
    .status         (status),
    .node_index     (node_index),
    .discovery_time (discovery_time),
    .finish_time    (finish_time),
    .predecessor    (predecessor),
    .last_result    (last_result)
  );

endmodule
